FILE: hdl/json_string_unescape_utf8_top_defines.svh
// assertion macros for the json string unescaper
`ifndef JSON_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH

// same-cycle implication
`define JSU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/jsu_pkg.sv
// shared types for the json string unescaper
package jsu_pkg;

	typedef enum logic [1:0] {
		K_DATA   = 2'd0,
		K_CLOSED = 2'd1,
		K_ERROR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		E_NO_QUOTE     = 3'd0,
		E_CONTROL      = 3'd1,
		E_BAD_ESCAPE   = 3'd2,
		E_BAD_HEX      = 3'd3,
		E_BAD_LOW      = 3'd4,
		E_UNTERMINATED = 3'd5
	} err_t;

	localparam int unsigned GRP_DEPTH = 4;

	typedef struct packed {
		logic       func;
		logic [7:0] in_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		kind_t      kind;
		err_t       error_code;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		kind_t      kind;
		err_t       error_code;
	} result_t;

	// results caused by one input byte, entry 0 first
	typedef struct packed {
		result_t [GRP_DEPTH-1:0] res;
		logic [2:0]              n;
	} group_t;

endpackage

FILE: hdl/jsu_stream_if.sv
// valid/ready stream channel
interface jsu_stream_if #(
	parameter type payload_t = logic [0:0]
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/json_string_unescape_utf8_top.sv
// json string unescaper to utf-8, top level
//
//  channel  dir  payload                              transfer
//  text     in   func, in_byte                        one text byte or end marker
//  result   out  out_byte, kind, error_code, last     one decoded result
//
// one input byte per cycle while bytes yield at most one result and result is ready;
// a byte with up to four results holds the result register until the last is taken
// input register, decode logic, result register: the path from byte to first result
// bytes with no result (opening quote, backslash, most hex digits) never wait on result
// text.ready falls only while the input register holds a byte whose results cannot
// yet enter the result register
// asynchronous reset returns the decoder to idle, waiting for an opening quote
module json_string_unescape_utf8_top import jsu_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	jsu_stream_if.sink   text,
	jsu_stream_if.source result
);

	logic     valid_s1;
	in_item_t item_s1;
	group_t   grp;
	logic     free;
	logic     advance;
	logic     load;

	assign advance = valid_s1 && (grp.n == 3'd0 || free);
	assign load = advance && grp.n != 3'd0;
	assign text.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) item_s1 <= text.payload;
	end

	jsu_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.grp    (grp)
	);

	jsu_out_buf u_out_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.grp    (grp),
		.free   (free),
		.result (result)
	);

endmodule

FILE: hdl/jsu_decode.sv
// decoder state register and next-state / result logic for one byte
module jsu_decode import jsu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  in_item_t item,
	output group_t   grp
);

	typedef enum logic [6:0] {
		M_IDLE          = 7'b0000001,
		M_STR           = 7'b0000010,
		M_ESC           = 7'b0000100,
		M_HEX           = 7'b0001000,
		M_AFTER_HIGH    = 7'b0010000,
		M_AFTER_HIGH_BS = 7'b0100000,
		M_LOW_HEX       = 7'b1000000
	} mode_t;

	typedef struct packed {
		logic    v;
		result_t r;
		mode_t   mode;
	} step_t;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6e;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [5:0] HIGH_TAG  = 6'b110110;
	localparam logic [5:0] LOW_TAG   = 6'b110111;
	localparam logic [20:0] PLANE1   = 21'h10000;

	mode_t       mode_q, nxt_mode;
	logic [15:0] acc_q, nxt_acc;
	logic [1:0]  cnt_q, nxt_cnt;
	logic [9:0]  high_q, nxt_high;

	logic        tail_v;
	result_t     tail_r;
	logic        enc_en;
	logic [20:0] cp;
	logic [4:0]  hv;
	logic [15:0] acc_sh;
	step_t       sb, eb;
	group_t      enc;
	logic [2:0]  enc_n;

	function automatic logic [4:0] hex_val(input logic [7:0] b);
		logic [4:0] v;
		v = 5'h10;
		if (b >= 8'h30 && b <= 8'h39) v = {1'b0, 4'(b - 8'h30)};
		else if (b >= 8'h61 && b <= 8'h66) v = {1'b0, 4'(b - 8'h57)};
		else if (b >= 8'h41 && b <= 8'h46) v = {1'b0, 4'(b - 8'h37)};
		return v;
	endfunction

	function automatic result_t data_res(input logic [7:0] b);
		result_t r;
		r.out_byte = b;
		r.kind = K_DATA;
		r.error_code = E_NO_QUOTE;
		return r;
	endfunction

	function automatic result_t err_res(input err_t code);
		result_t r;
		r.out_byte = 8'h00;
		r.kind = K_ERROR;
		r.error_code = code;
		return r;
	endfunction

	function automatic step_t string_byte(input logic [7:0] b);
		step_t s;
		s.v = 1'b1;
		s.mode = M_STR;
		s.r = data_res(b);
		if (b == CH_QUOTE) begin
			s.r.kind = K_CLOSED;
			s.r.out_byte = 8'h00;
			s.mode = M_IDLE;
		end else if (b < CH_SPACE) begin
			s.r = err_res(E_CONTROL);
			s.mode = M_IDLE;
		end else if (b == CH_BSLASH) begin
			s.v = 1'b0;
			s.mode = M_ESC;
		end
		return s;
	endfunction

	function automatic step_t escape_byte(input logic [7:0] b);
		step_t s;
		s.v = 1'b1;
		s.mode = M_STR;
		s.r = data_res(b);
		case (b)
			CH_QUOTE, CH_BSLASH, CH_SLASH: s.r = data_res(b);
			CH_B: s.r = data_res(8'h08);
			CH_F: s.r = data_res(8'h0c);
			CH_N: s.r = data_res(8'h0a);
			CH_R: s.r = data_res(8'h0d);
			CH_T: s.r = data_res(8'h09);
			CH_U: begin
				s.v = 1'b0;
				s.mode = M_HEX;
			end
			default: begin
				s.r = err_res(E_BAD_ESCAPE);
				s.mode = M_IDLE;
			end
		endcase
		return s;
	endfunction

	function automatic group_t utf8_enc(input logic [20:0] c);
		group_t g;
		g = '0;
		if (c <= 21'h7f) begin
			g.n = 3'd1;
			g.res[0] = data_res(c[7:0]);
		end else if (c <= 21'h7ff) begin
			g.n = 3'd2;
			g.res[0] = data_res({3'b110, c[10:6]});
			g.res[1] = data_res({2'b10, c[5:0]});
		end else if (c <= 21'hffff) begin
			g.n = 3'd3;
			g.res[0] = data_res({4'b1110, c[15:12]});
			g.res[1] = data_res({2'b10, c[11:6]});
			g.res[2] = data_res({2'b10, c[5:0]});
		end else begin
			g.n = 3'd4;
			g.res[0] = data_res({5'b11110, c[20:18]});
			g.res[1] = data_res({2'b10, c[17:12]});
			g.res[2] = data_res({2'b10, c[11:6]});
			g.res[3] = data_res({2'b10, c[5:0]});
		end
		return g;
	endfunction

	always_comb begin
		nxt_mode = mode_q;
		nxt_acc = acc_q;
		nxt_cnt = cnt_q;
		nxt_high = high_q;
		tail_v = 1'b0;
		tail_r = data_res(8'h00);
		enc_en = 1'b0;
		cp = '0;
		hv = hex_val(item.in_byte);
		acc_sh = {acc_q[11:0], hv[3:0]};
		sb = string_byte(item.in_byte);
		eb = escape_byte(item.in_byte);
		unique case (mode_q)
			M_IDLE: begin
				if (item.func || item.in_byte != CH_QUOTE) begin
					tail_v = 1'b1;
					tail_r = err_res(E_NO_QUOTE);
				end else begin
					nxt_mode = M_STR;
				end
			end
			M_STR: begin
				if (item.func) begin
					tail_v = 1'b1;
					tail_r = err_res(E_UNTERMINATED);
					nxt_mode = M_IDLE;
				end else begin
					tail_v = sb.v;
					tail_r = sb.r;
					nxt_mode = sb.mode;
				end
			end
			M_ESC: begin
				if (item.func) begin
					tail_v = 1'b1;
					tail_r = err_res(E_UNTERMINATED);
					nxt_mode = M_IDLE;
				end else begin
					tail_v = eb.v;
					tail_r = eb.r;
					nxt_mode = eb.mode;
					if (eb.mode == M_HEX) begin
						nxt_acc = '0;
						nxt_cnt = '0;
					end
				end
			end
			M_HEX: begin
				if (item.func) begin
					tail_v = 1'b1;
					tail_r = err_res(E_UNTERMINATED);
					nxt_mode = M_IDLE;
				end else if (hv[4]) begin
					tail_v = 1'b1;
					tail_r = err_res(E_BAD_HEX);
					nxt_mode = M_IDLE;
				end else begin
					nxt_acc = acc_sh;
					nxt_cnt = cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						if (acc_sh[15:10] == HIGH_TAG) begin
							nxt_high = acc_sh[9:0];
							nxt_mode = M_AFTER_HIGH;
						end else begin
							enc_en = 1'b1;
							cp = {5'b0, acc_sh};
							nxt_mode = M_STR;
						end
					end
				end
			end
			M_AFTER_HIGH: begin
				if (!item.func && item.in_byte == CH_BSLASH) begin
					nxt_mode = M_AFTER_HIGH_BS;
				end else begin
					enc_en = 1'b1;
					cp = {5'b0, HIGH_TAG, high_q};
					if (item.func) begin
						tail_v = 1'b1;
						tail_r = err_res(E_UNTERMINATED);
						nxt_mode = M_IDLE;
					end else begin
						tail_v = sb.v;
						tail_r = sb.r;
						nxt_mode = sb.mode;
					end
				end
			end
			M_AFTER_HIGH_BS: begin
				if (!item.func && item.in_byte == CH_U) begin
					nxt_mode = M_LOW_HEX;
					nxt_acc = '0;
					nxt_cnt = '0;
				end else begin
					enc_en = 1'b1;
					cp = {5'b0, HIGH_TAG, high_q};
					if (item.func) begin
						tail_v = 1'b1;
						tail_r = err_res(E_UNTERMINATED);
						nxt_mode = M_IDLE;
					end else begin
						tail_v = eb.v;
						tail_r = eb.r;
						nxt_mode = eb.mode;
						if (eb.mode == M_HEX) begin
							nxt_acc = '0;
							nxt_cnt = '0;
						end
					end
				end
			end
			M_LOW_HEX: begin
				if (item.func) begin
					tail_v = 1'b1;
					tail_r = err_res(E_UNTERMINATED);
					nxt_mode = M_IDLE;
				end else if (hv[4]) begin
					tail_v = 1'b1;
					tail_r = err_res(E_BAD_HEX);
					nxt_mode = M_IDLE;
				end else begin
					nxt_acc = acc_sh;
					nxt_cnt = cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						if (acc_sh[15:10] != LOW_TAG) begin
							tail_v = 1'b1;
							tail_r = err_res(E_BAD_LOW);
							nxt_mode = M_IDLE;
						end else begin
							enc_en = 1'b1;
							cp = PLANE1 + {1'b0, high_q, acc_sh[9:0]};
							nxt_mode = M_STR;
						end
					end
				end
			end
			default: nxt_mode = M_IDLE;
		endcase
		if (nxt_mode == M_IDLE) begin
			nxt_acc = '0;
			nxt_cnt = '0;
			nxt_high = '0;
		end
	end

	// utf-8 bytes first, then the single closing, error or data result
	always_comb begin
		enc = utf8_enc(cp);
		enc_n = enc_en ? enc.n : 3'd0;
		grp = '0;
		for (int i = 0; i < GRP_DEPTH; i++) begin
			if (3'(i) < enc_n) grp.res[i] = enc.res[i];
			else if (3'(i) == enc_n) grp.res[i] = tail_r;
			else grp.res[i] = data_res(8'h00);
		end
		grp.n = enc_n + {2'b0, tail_v};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			acc_q <= '0;
			cnt_q <= '0;
			high_q <= '0;
		end else if (step) begin
			mode_q <= nxt_mode;
			acc_q <= nxt_acc;
			cnt_q <= nxt_cnt;
			high_q <= nxt_high;
		end
	end

endmodule

FILE: hdl/jsu_out_buf.sv
// result register that sends a group of results one transfer at a time
`include "json_string_unescape_utf8_top_defines.svh"

module jsu_out_buf import jsu_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  group_t       grp,
	output logic         free,
	jsu_stream_if.source result
);

	group_t     grp_q;
	logic [1:0] idx_q;
	logic       valid_q;
	logic [2:0] idx_inc;
	logic       last_now;
	logic       fire;
	result_t    cur;

	assign idx_inc = {1'b0, idx_q} + 3'd1;
	assign last_now = idx_inc == grp_q.n;
	assign fire = valid_q && result.ready;
	assign free = !valid_q || (result.ready && last_now);
	assign cur = grp_q.res[idx_q];

	assign result.valid = valid_q;
	assign result.payload = out_item_t'{
		out_byte: cur.out_byte,
		kind: cur.kind,
		error_code: cur.error_code,
		last: last_now
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q <= '0;
		end else if (fire) begin
			if (last_now) valid_q <= 1'b0;
			else idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) grp_q <= grp;
	end

	`JSU_ASSERT_NOW(a_grp_count, clk, arst_n, valid_q, grp_q.n != 3'd0 && grp_q.n <= 3'd4, "result group count out of range")
	`JSU_ASSERT_NOW(a_load_free, clk, arst_n, load, free, "group loaded over an undelivered one")
	`JSU_ASSERT_NEXT(a_drain, clk, arst_n, fire && last_now && !load, !valid_q, "buffer still valid after its last transfer")
	`JSU_ASSERT_NEXT(a_advance, clk, arst_n, fire && !last_now, valid_q && idx_q == $past(idx_q) + 2'd1, "result index did not advance")

endmodule

FILE: bench/jsu_decode_check.sv
// checker for the json string unescaper: predicts decoded results and compares them
module jsu_decode_check import jsu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      text_valid,
	input  logic      text_ready,
	input  in_item_t  text_payload,
	input  logic      result_valid,
	input  logic      result_ready,
	input  out_item_t result_payload,
	output int        errors,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {
		S_IDLE,
		S_STR,
		S_ESC,
		S_HEX,
		S_AFTER_HIGH,
		S_AFTER_HIGH_BS,
		S_LOW_HEX
	} dec_state_t;

	localparam logic [7:0] QUOTE  = 8'h22;
	localparam logic [7:0] BSLASH = 8'h5c;
	localparam logic [7:0] CH_U   = 8'h75;
	// error code field reads zero outside error results
	localparam err_t CODE_NONE = E_NO_QUOTE;

	dec_state_t  st = S_IDLE;
	logic [15:0] acc = '0;
	logic [15:0] hi = '0;
	logic [1:0]  ndig = '0;
	out_item_t   utf8_due[$];
	out_item_t   step_res[$];
	int          mism = 0;
	int          due_n = 0;

	assign errors  = mism;
	assign pending = due_n;

	task automatic emit(logic [7:0] b, kind_t k, err_t c);
		out_item_t r;
		r.out_byte = b;
		r.kind = k;
		r.error_code = c;
		r.last = 1'b0;
		if (step_res.size() < GRP_DEPTH)
			step_res.insert(step_res.size(), r);
	endtask

	task automatic data_out(logic [7:0] b);
		emit(b, K_DATA, CODE_NONE);
	endtask

	task automatic go_idle();
		st = S_IDLE;
		acc = '0;
		ndig = '0;
		hi = '0;
	endtask

	task automatic fail(err_t c);
		emit(8'h00, K_ERROR, c);
		go_idle();
	endtask

	task automatic utf8(logic [20:0] cp);
		if (cp <= 21'h7f) begin
			data_out(cp[7:0]);
		end else if (cp <= 21'h7ff) begin
			data_out({3'b110, cp[10:6]});
			data_out({2'b10, cp[5:0]});
		end else if (cp <= 21'hffff) begin
			data_out({4'b1110, cp[15:12]});
			data_out({2'b10, cp[11:6]});
			data_out({2'b10, cp[5:0]});
		end else begin
			data_out({5'b11110, cp[20:18]});
			data_out({2'b10, cp[17:12]});
			data_out({2'b10, cp[11:6]});
			data_out({2'b10, cp[5:0]});
		end
	endtask

	function automatic logic [4:0] hex_val(logic [7:0] b);
		if (b >= 8'h30 && b <= 8'h39)
			return {1'b0, b[3:0]};
		if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
			return 5'(b[2:0] + 4'd9);
		return 5'd16;
	endfunction

	task automatic string_byte(logic [7:0] b);
		if (b == QUOTE) begin
			emit(8'h00, K_CLOSED, CODE_NONE);
			go_idle();
		end else if (b < 8'h20) begin
			fail(E_CONTROL);
		end else if (b == BSLASH) begin
			st = S_ESC;
		end else begin
			data_out(b);
		end
	endtask

	task automatic escape_byte(logic [7:0] b);
		st = S_STR;
		case (b)
			8'h22: data_out(8'h22);
			8'h5c: data_out(8'h5c);
			8'h2f: data_out(8'h2f);
			8'h62: data_out(8'h08);
			8'h66: data_out(8'h0c);
			8'h6e: data_out(8'h0a);
			8'h72: data_out(8'h0d);
			8'h74: data_out(8'h09);
			CH_U: begin
				st = S_HEX;
				acc = '0;
				ndig = '0;
			end
			default: fail(E_BAD_ESCAPE);
		endcase
	endtask

	task automatic hex_digit(logic [7:0] b, output bit done);
		logic [4:0] d;
		d = hex_val(b);
		done = 1'b0;
		if (d[4]) begin
			fail(E_BAD_HEX);
		end else begin
			acc = {acc[11:0], d[3:0]};
			if (ndig == 2'd3) begin
				ndig = '0;
				done = 1'b1;
			end else begin
				ndig = ndig + 2'd1;
			end
		end
	endtask

	task automatic decode_item(in_item_t it);
		bit          at_end;
		logic [7:0]  b;
		bit          done;
		at_end = it.func;
		b = it.in_byte;
		step_res.delete();
		case (st)
			S_IDLE: begin
				if (at_end || b != QUOTE)
					fail(E_NO_QUOTE);
				else
					st = S_STR;
			end
			S_STR: begin
				if (at_end) fail(E_UNTERMINATED);
				else string_byte(b);
			end
			S_ESC: begin
				if (at_end) fail(E_UNTERMINATED);
				else escape_byte(b);
			end
			S_HEX: begin
				if (at_end) begin
					fail(E_UNTERMINATED);
				end else begin
					hex_digit(b, done);
					if (done) begin
						if (acc >= 16'hd800 && acc <= 16'hdbff) begin
							hi = acc;
							st = S_AFTER_HIGH;
						end else begin
							utf8({5'b0, acc});
							st = S_STR;
						end
					end
				end
			end
			S_AFTER_HIGH: begin
				if (!at_end && b == BSLASH) begin
					st = S_AFTER_HIGH_BS;
				end else begin
					utf8({5'b0, hi});
					st = S_STR;
					if (at_end) fail(E_UNTERMINATED);
					else string_byte(b);
				end
			end
			S_AFTER_HIGH_BS: begin
				if (!at_end && b == CH_U) begin
					st = S_LOW_HEX;
					acc = '0;
					ndig = '0;
				end else begin
					utf8({5'b0, hi});
					if (at_end) fail(E_UNTERMINATED);
					else escape_byte(b);
				end
			end
			S_LOW_HEX: begin
				if (at_end) begin
					fail(E_UNTERMINATED);
				end else begin
					hex_digit(b, done);
					if (done) begin
						if (acc < 16'hdc00 || acc > 16'hdfff) begin
							fail(E_BAD_LOW);
						end else begin
							utf8(21'h10000 + {1'b0, hi[9:0], 10'b0} + {11'b0, acc[9:0]});
							st = S_STR;
						end
					end
				end
			end
			default: go_idle();
		endcase
		if (step_res.size() > 0)
			step_res[step_res.size() - 1].last = 1'b1;
		foreach (step_res[i])
			utf8_due.insert(utf8_due.size(), step_res[i]);
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			mism++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			go_idle();
			utf8_due.delete();
		end else begin
			if (text_valid && text_ready)
				decode_item(text_payload);
			if (result_valid && result_ready) begin
				if (utf8_due.size() == 0) begin
					$display("%0t: unexpected result expected none got %h", $time,
						result_payload);
					mism++;
				end else begin
					want = utf8_due.pop_front();
					check_field("out_byte", want.out_byte, result_payload.out_byte);
					check_field("kind", want.kind, result_payload.kind);
					check_field("error_code", want.error_code, result_payload.error_code);
					check_field("last", want.last, result_payload.last);
				end
			end
		end
		due_n = utf8_due.size();
	end

endmodule

FILE: bench/tb.sv
// testbench top for the json string unescaper: stimulus, receiver pacing and verdict
module tb import jsu_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] QUOTE  = 8'h22;
	localparam logic [7:0] BSLASH = 8'h5c;
	localparam logic [7:0] CH_U   = 8'h75;
	localparam int RANDOM_ITEMS   = 320;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors;
	int   pending;
	int   idle_pct = 0;
	int   stall_pct = 0;
	bit   hold_req = 1'b0;
	int   sent = 0;

	in_item_t   text_q[$];
	logic [7:0] esc_letters[8] = '{8'h22, 8'h5c, 8'h2f, 8'h62, 8'h66, 8'h6e, 8'h72, 8'h74};
	logic [7:0] non_hex[8] = '{8'h47, 8'h67, 8'h2f, 8'h3a, 8'h40, 8'h60, 8'h22, 8'h80};

	jsu_stream_if #(.payload_t(in_item_t))  text();
	jsu_stream_if #(.payload_t(out_item_t)) result();

	always #5 clk = ~clk;

	json_string_unescape_utf8_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.result (result)
	);

	jsu_decode_check decode_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.text_valid     (text.valid),
		.text_ready     (text.ready),
		.text_payload   (text.payload),
		.result_valid   (result.valid),
		.result_ready   (result.ready),
		.result_payload (result.payload),
		.errors         (errors),
		.pending        (pending)
	);

	task automatic add_b(logic [7:0] b);
		text_q.insert(text_q.size(), {1'b0, b});
	endtask

	task automatic add_end();
		text_q.insert(text_q.size(), {1'b1, 8'($urandom)});
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] v);
		if (v < 4'd10)
			return 8'h30 + v;
		return ($urandom_range(1) ? 8'h61 : 8'h41) + v - 8'd10;
	endfunction

	task automatic add_u(logic [15:0] v);
		add_b(BSLASH);
		add_b(CH_U);
		for (int i = 3; i >= 0; i--)
			add_b(hex_char(v[i*4 +: 4]));
	endtask

	function automatic logic [15:0] high_sur();
		case ($urandom_range(3))
			0: return 16'hd800;
			1: return 16'hdbff;
			default: return 16'hd800 + 16'($urandom_range(16'h3ff));
		endcase
	endfunction

	function automatic logic [15:0] low_sur();
		case ($urandom_range(3))
			0: return 16'hdc00;
			1: return 16'hdfff;
			default: return 16'hdc00 + 16'($urandom_range(16'h3ff));
		endcase
	endfunction

	task automatic add_token();
		int n;
		case ($urandom_range(14))
			0, 1, 2: add_b(8'($urandom_range(255, 32)));
			3: begin
				add_b(BSLASH);
				add_b(esc_letters[$urandom_range(7)]);
			end
			4: add_u(16'($urandom_range(16'h7f)));
			5: add_u(16'($urandom_range(16'h7ff, 16'h80)));
			6: add_u(16'($urandom));
			7: begin
				add_u(high_sur());
				add_u(low_sur());
			end
			8: add_u(high_sur());
			9: begin
				add_u(high_sur());
				add_b(BSLASH);
				if ($urandom_range(1))
					add_b(esc_letters[$urandom_range(7)]);
				else
					add_b(8'($urandom));
			end
			10: begin
				add_u(high_sur());
				if ($urandom_range(1))
					add_u(16'($urandom_range(16'hdbff)));
				else
					add_u(16'($urandom_range(16'hffff, 16'he000)));
			end
			11: add_u(low_sur());
			12: begin
				if ($urandom_range(1))
					add_u(high_sur());
				add_b(BSLASH);
				add_b(CH_U);
				n = $urandom_range(3);
				repeat (n) add_b(hex_char(4'($urandom)));
				add_b(non_hex[$urandom_range(7)] | ($urandom_range(3) == 0 ? 8'h80 : 8'h00));
			end
			13: add_b(8'($urandom_range(31)));
			default: begin
				add_b(BSLASH);
				add_b(8'($urandom));
			end
		endcase
	endtask

	task automatic add_string();
		int n;
		if ($urandom_range(9) == 0) begin
			// noise
			n = $urandom_range(6, 1);
			repeat (n) text_q.insert(text_q.size(), 9'($urandom));
			return;
		end
		add_b(QUOTE);
		n = $urandom_range(6);
		repeat (n) add_token();
		case ($urandom_range(9))
			7: add_end();
			8: begin
				add_b(BSLASH);
				add_end();
			end
			9: ;
			default: add_b(QUOTE);
		endcase
	endtask

	task automatic send(in_item_t it);
		bit rdy;
		while ($urandom_range(99) < idle_pct) begin
			text.valid <= 1'b0;
			@(posedge clk);
		end
		text.valid <= 1'b1;
		text.payload <= it;
		do begin
			@(negedge clk);
			rdy = text.ready;
			@(posedge clk);
		end while (!rdy);
	endtask

	task automatic flush();
		while (text_q.size() > 0) begin
			send(text_q.pop_front());
			sent++;
		end
	endtask

	// receiver pacing, with one long hold-off when asked
	initial begin : rx
		int  hold;
		bit  held;
		hold = 0;
		held = 1'b0;
		result.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				hold = 400;
			end
			if (hold > 0) begin
				hold--;
				result.ready <= 1'b0;
			end else begin
				result.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin
		#2ms;
		$display("tb: FAIL");
		$finish;
	end

	initial begin : stim
		int idle_tab[4];
		int stall_tab[4];
		int target;
		idle_tab = '{0, 72, 0, 22};
		stall_tab = '{0, 0, 72, 22};
		text.valid = 1'b0;
		text.payload = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		add_end();
		add_b(8'h41);
		add_b(QUOTE);
		add_b(8'h20);
		add_b(8'hff);
		add_b(8'h1f);
		add_b(QUOTE);
		add_u(16'hdbff);
		add_u(16'hdfff);
		add_b(BSLASH);
		add_b(8'h78);
		add_b(QUOTE);
		add_end();
		flush();

		for (int p = 0; p < 4; p++) begin
			idle_pct = idle_tab[p];
			stall_pct <= stall_tab[p];
			if (p == 0)
				hold_req <= 1'b1;
			target = sent + RANDOM_ITEMS / 4;
			while (sent < target) begin
				add_string();
				flush();
			end
		end

		text.valid <= 1'b0;
		stall_pct <= 0;
		do @(negedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/jsu_pkg.sv
hdl/jsu_stream_if.sv
hdl/jsu_decode.sv
hdl/jsu_out_buf.sv
hdl/json_string_unescape_utf8_top.sv
bench/jsu_decode_check.sv
bench/tb.sv
